>>> rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion shorthands clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When cond holds, prop must hold in the same cycle.
`define ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// When cond holds, prop must hold in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/tle_pkg.sv
// ============================================================================
// tle_pkg
// Shared geometry, key codes, word types and state codes of the line editor.
// ============================================================================
package tle_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 64;
    localparam int COL_W  = $clog2(COLS);
    localparam int COLC_W = $clog2(COLS + 1);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int CELL_W = 16;

    localparam logic [7:0] KEY_BACKSPACE = 8'h08;
    localparam logic [7:0] KEY_DELETE    = 8'h7F;
    localparam logic [7:0] KEY_LEFT      = 8'h1B;
    localparam logic [7:0] KEY_RIGHT     = 8'h1A;
    localparam logic [7:0] KEY_HOME      = 8'h02;
    localparam logic [7:0] KEY_END       = 8'h03;
    localparam logic [7:0] KEY_ENTER     = 8'h0D;
    localparam logic [7:0] BLANK         = 8'h20;
    localparam logic [7:0] COLOR_RESET   = 8'h0F;
    localparam logic       KIND_READ     = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] key_code;
        logic [5:0] read_row;
        logic [6:0] read_column;
    } item_t;

    typedef struct packed {
        logic [6:0] cursor_column;
        logic [5:0] cursor_row;
        logic       line_done;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
    } result_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] color;
    } cell_t;

    typedef struct packed {
        logic ready;
        logic res_valid;
    } eng_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SHL,
        ST_SHR,
        ST_END,
        ST_DONE
    } state_t;

endpackage

>>> rtl/tle_ram.sv
// ============================================================================
// tle_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ============================================================================
module tle_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 13
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tle_engine.sv
// ============================================================================
// tle_engine
// Edit sequencer: clears the screen RAM, then walks one row per key for
// shifts and the End scan, reading one cell and writing one cell a cycle.
// ============================================================================
module tle_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  tle_pkg::item_t              item,
    input  logic [7:0]                  text_color,
    input  logic                        res_take,
    output tle_pkg::eng_stat_t          stat,
    output tle_pkg::result_t            res,
    output logic                        mem_we,
    output logic [tle_pkg::ADDR_W-1:0]  mem_waddr,
    output logic [tle_pkg::CELL_W-1:0]  mem_wdata,
    output logic                        mem_re,
    output logic [tle_pkg::ADDR_W-1:0]  mem_raddr,
    input  logic [tle_pkg::CELL_W-1:0]  mem_rdata
);

    localparam int COL_W  = tle_pkg::COL_W;
    localparam int COLC_W = tle_pkg::COLC_W;
    localparam int ROW_W  = tle_pkg::ROW_W;
    localparam int ADDR_W = tle_pkg::ADDR_W;

    tle_pkg::state_t     state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [COLC_W-1:0]   scan_reg, scan_next;
    logic [COL_W-1:0]    wcol_reg, wcol_next;
    logic                pend_reg, pend_next;
    logic [7:0]          key_reg, key_next;
    logic                done_reg, done_next;
    tle_pkg::cell_t      cell_reg, cell_next;
    tle_pkg::cell_t      rd_cell;
    tle_pkg::cell_t      new_cell;
    logic                rd_go;
    logic                in_range;

    assign rd_cell  = tle_pkg::cell_t'(mem_rdata);
    assign new_cell = '{ch: key_reg, color: text_color};
    assign in_range = (int'(item.read_row) < tle_pkg::ROWS)
                   && (int'(item.read_column) < tle_pkg::COLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tle_pkg::ST_CLEAR;
            col_reg   <= '0;
            row_reg   <= '0;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        wcol_reg <= wcol_next;
        key_reg  <= key_next;
        cell_reg <= cell_next;
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        clr_next   = clr_reg;
        scan_next  = scan_reg;
        wcol_next  = wcol_reg;
        pend_next  = pend_reg;
        key_next   = key_reg;
        done_next  = done_reg;
        cell_next  = cell_reg;
        rd_go      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = {row_reg, wcol_reg};
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = {row_reg, scan_reg[COL_W-1:0]};

        unique case (state_reg)
            tle_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {tle_pkg::BLANK, 8'h00};
                clr_next  = clr_reg + ADDR_W'(1);
                if (&clr_reg)
                begin
                    state_next = tle_pkg::ST_IDLE;
                end
            end

            tle_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b0;
                    cell_next = '0;
                    key_next  = item.key_code;
                    pend_next = 1'b0;
                    if (item.kind == tle_pkg::KIND_READ)
                    begin
                        mem_re     = in_range;
                        mem_raddr  = {ROW_W'(item.read_row), COL_W'(item.read_column)};
                        pend_next  = in_range;
                        state_next = tle_pkg::ST_READ;
                    end
                    else
                    begin
                        unique case (item.key_code)
                            tle_pkg::KEY_BACKSPACE:
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next   = col_reg - COL_W'(1);
                                    scan_next  = COLC_W'(col_reg);
                                    state_next = tle_pkg::ST_SHL;
                                end
                                else
                                begin
                                    state_next = tle_pkg::ST_DONE;
                                end
                            end
                            tle_pkg::KEY_DELETE:
                            begin
                                scan_next  = COLC_W'(col_reg) + COLC_W'(1);
                                state_next = tle_pkg::ST_SHL;
                            end
                            tle_pkg::KEY_LEFT:
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next = col_reg - COL_W'(1);
                                end
                                state_next = tle_pkg::ST_DONE;
                            end
                            tle_pkg::KEY_RIGHT:
                            begin
                                if (col_reg != COL_W'(tle_pkg::COLS - 1))
                                begin
                                    col_next = col_reg + COL_W'(1);
                                end
                                state_next = tle_pkg::ST_DONE;
                            end
                            tle_pkg::KEY_HOME:
                            begin
                                col_next   = '0;
                                state_next = tle_pkg::ST_DONE;
                            end
                            tle_pkg::KEY_END:
                            begin
                                scan_next  = COLC_W'(tle_pkg::COLS);
                                state_next = tle_pkg::ST_END;
                            end
                            tle_pkg::KEY_ENTER:
                            begin
                                col_next   = '0;
                                row_next   = (row_reg == ROW_W'(tle_pkg::ROWS - 1))
                                           ? '0 : row_reg + ROW_W'(1);
                                done_next  = 1'b1;
                                state_next = tle_pkg::ST_DONE;
                            end
                            default:
                            begin
                                scan_next  = COLC_W'(tle_pkg::COLS - 1);
                                state_next = tle_pkg::ST_SHR;
                            end
                        endcase
                    end
                end
            end

            tle_pkg::ST_READ:
            begin
                if (pend_reg)
                begin
                    cell_next = rd_cell;
                end
                pend_next  = 1'b0;
                state_next = tle_pkg::ST_DONE;
            end

            // Pull cells left: read column scan, write it one column lower next cycle.
            tle_pkg::ST_SHL:
            begin
                rd_go = scan_reg < COLC_W'(tle_pkg::COLS);
                if (rd_go)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {row_reg, scan_reg[COL_W-1:0]};
                    scan_next = scan_reg + COLC_W'(1);
                    wcol_next = COL_W'(scan_reg - COLC_W'(1));
                end
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                pend_next = rd_go;
                if (!rd_go && !pend_reg)
                begin
                    state_next = tle_pkg::ST_DONE;
                end
            end

            // Push cells right from the end of the row down to the cursor, then drop
            // the new character in at the cursor.
            tle_pkg::ST_SHR:
            begin
                rd_go = scan_reg > COLC_W'(col_reg);
                if (rd_go)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {row_reg, COL_W'(scan_reg - COLC_W'(1))};
                    scan_next = scan_reg - COLC_W'(1);
                    wcol_next = scan_reg[COL_W-1:0];
                end
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                pend_next = rd_go;
                if (!rd_go && !pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {row_reg, col_reg};
                    mem_wdata = new_cell;
                    if (col_reg != COL_W'(tle_pkg::COLS - 1))
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                    state_next = tle_pkg::ST_DONE;
                end
            end

            // Scan from the last column down for the rightmost non-space cell.
            tle_pkg::ST_END:
            begin
                rd_go = scan_reg != '0;
                if (rd_go)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {row_reg, COL_W'(scan_reg - COLC_W'(1))};
                    scan_next = scan_reg - COLC_W'(1);
                    wcol_next = COL_W'(scan_reg - COLC_W'(1));
                end
                pend_next = rd_go;
                if (pend_reg && (rd_cell.ch != tle_pkg::BLANK))
                begin
                    col_next   = (wcol_reg == COL_W'(tle_pkg::COLS - 1))
                               ? wcol_reg : wcol_reg + COL_W'(1);
                    pend_next  = 1'b0;
                    state_next = tle_pkg::ST_DONE;
                end
                else if (!rd_go && !pend_reg)
                begin
                    col_next   = '0;
                    state_next = tle_pkg::ST_DONE;
                end
            end

            tle_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = tle_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tle_pkg::ST_IDLE;
            end
        endcase
    end

    assign stat.ready     = (state_reg == tle_pkg::ST_IDLE);
    assign stat.res_valid = (state_reg == tle_pkg::ST_DONE);

    assign res.cursor_column = 7'(col_reg);
    assign res.cursor_row    = 6'(row_reg);
    assign res.line_done     = done_reg;
    assign res.cell_char     = cell_reg.ch;
    assign res.cell_color    = cell_reg.color;

endmodule

>>> rtl/text_line_editor.sv
// ============================================================================
// text_line_editor
// Key-driven editor of a character/colour text screen with a cursor.
// ============================================================================
// Usage:
//   item channel (item_valid / item_stall / item): one word per key press or
//   cell read. item_stall is high while an item is in work, so one item is
//   in flight at a time.
//   result channel (result_valid / result_stall / result): one word per item,
//   held in an output register; the next item is taken while a finished
//   word still waits there, and a result stalled on result_stall holds.
//   text_color_we / text_color: write the colour used for inserted chars;
//   write only while no item is in work.
// Flow: moves, Home, Enter and Backspace at column 0 go from accept straight
//   to the done state; a cell read passes a read state first, and Backspace
//   elsewhere, Delete, insert and End walk the row first. The row walk reads
//   and writes one RAM cell per cycle, which sets the rate of those keys.
// Reset: the cursor goes to the top-left cell and the colour to 0x0F; a
//   clearing pass then writes space with colour 0 to all 2^(ROW_W+COL_W)
//   RAM entries (8192 at 64 x 80), with item_stall high meanwhile.
// ============================================================================
`include "assert_macros.svh"

module text_line_editor (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  tle_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output tle_pkg::result_t  result,
    input  logic              text_color_we,
    input  logic [7:0]        text_color
);

    tle_pkg::eng_stat_t              stat;
    tle_pkg::result_t                eng_res;
    tle_pkg::result_t                out_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [7:0]                      color_reg;
    logic                            accept;
    logic                            res_take;
    logic                            res_load;
    logic                            mem_we;
    logic [tle_pkg::ADDR_W-1:0]      mem_waddr;
    logic [tle_pkg::CELL_W-1:0]      mem_wdata;
    logic                            mem_re;
    logic [tle_pkg::ADDR_W-1:0]      mem_raddr;
    logic [tle_pkg::CELL_W-1:0]      mem_rdata;

    // Take a new word only when the sequencer sits idle.
    assign item_stall = !stat.ready;
    assign accept     = item_valid && !item_stall;

    // Move the finished word into the output register whenever it is free
    // or being emptied this cycle.
    assign res_take = !out_valid_reg || !result_stall;
    assign res_load = stat.res_valid && res_take;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            color_reg     <= tle_pkg::COLOR_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (text_color_we)
            begin
                color_reg <= text_color;
            end
        end
    end

    // Hold the result word until the receiver takes it.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= eng_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    tle_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .item       (item),
        .text_color (color_reg),
        .res_take   (res_take),
        .stat       (stat),
        .res        (eng_res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // Screen RAM: one entry per cell, character in the upper byte and colour
    // in the lower byte, addressed as {row, column}. The walks never read and
    // write the same entry in one cycle, so no bypass is needed.
    tle_ram #(
        .DATA_W (tle_pkg::CELL_W),
        .ADDR_W (tle_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    `ASSERT_NEXT(a_busy_after_accept, accept, !stat.ready, "sequencer idle right after accept")
    `ASSERT_SAME(a_ready_vs_result, stat.ready, !stat.res_valid, "idle and result at once")
    `ASSERT_SAME(a_enter_home, result_valid && result.line_done,
        (result.cursor_column == 7'd0) && (result.cell_char == 8'd0),
        "line end word with cursor off column zero or cell data")

endmodule

>>> tb/text_line_editor_tb.sv
// ============================================================================
// text_line_editor_tb
// Self-checking bench for the key-driven text screen editor. A screen model
// kept in the bench replays every accepted key or cell read and queues the
// word the block must answer. Directed tests cover reset contents, cursor
// edges, the End scan and the insert colour. Random line-editing sessions
// follow, with random gaps and result stalls and changing colours.
// ============================================================================
module text_line_editor_tb;

    localparam int   MAX_GAP      = 17;
    localparam int   RANDOM_WORDS = 1900;
    localparam int   REPORT_LIMIT = 10;
    localparam logic KIND_KEY     = ~tle_pkg::KIND_READ;

    logic             clk;
    logic             rst_n         = 1'b0;
    logic             item_valid    = 1'b0;
    logic             item_stall;
    tle_pkg::item_t   item          = '0;
    logic             result_valid;
    logic             result_stall  = 1'b0;
    tle_pkg::result_t result;
    logic             text_color_we = 1'b0;
    logic       [7:0] text_color    = tle_pkg::COLOR_RESET;

    // Screen model: characters, colours, cursor and the insert colour.
    logic [7:0] scr_char  [tle_pkg::ROWS][tle_pkg::COLS];
    logic [7:0] scr_color [tle_pkg::ROWS][tle_pkg::COLS];
    int         cur_col;
    int         cur_row;
    logic [7:0] ins_color;

    tle_pkg::result_t awaited_words [$];
    int               words_sent    = 0;
    int               fail_count    = 0;
    int               max_gap       = MAX_GAP;

    text_line_editor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .text_color_we (text_color_we),
        .text_color    (text_color)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Screen model
    // ------------------------------------------------------------------------

    // Remove the cell at col; the right part moves left, the last column stays.
    function automatic void drop_cell(int row, int col);
        for (int c = col; c + 1 < tle_pkg::COLS; c++)
        begin
            scr_char[row][c]  = scr_char[row][c + 1];
            scr_color[row][c] = scr_color[row][c + 1];
        end
    endfunction

    // Apply one word to the screen model and return the answer it must give.
    function automatic tle_pkg::result_t edit_screen(tle_pkg::item_t it);
        tle_pkg::result_t r;
        int               c;
        r = '0;
        if (it.kind == tle_pkg::KIND_READ)
        begin
            if (it.read_row < tle_pkg::ROWS && it.read_column < tle_pkg::COLS)
            begin
                r.cell_char  = scr_char[it.read_row][it.read_column];
                r.cell_color = scr_color[it.read_row][it.read_column];
            end
        end
        else
        begin
            case (it.key_code)
                tle_pkg::KEY_BACKSPACE:
                begin
                    if (cur_col > 0)
                    begin
                        cur_col--;
                        drop_cell(cur_row, cur_col);
                    end
                end
                tle_pkg::KEY_DELETE: drop_cell(cur_row, cur_col);
                tle_pkg::KEY_LEFT:   if (cur_col > 0) cur_col--;
                tle_pkg::KEY_RIGHT:  if (cur_col + 1 < tle_pkg::COLS) cur_col++;
                tle_pkg::KEY_HOME:   cur_col = 0;
                tle_pkg::KEY_END:
                begin
                    // A full last column pins the cursor there; otherwise go
                    // one past the rightmost character, 0 on a blank row.
                    if (scr_char[cur_row][tle_pkg::COLS - 1] != tle_pkg::BLANK)
                        cur_col = tle_pkg::COLS - 1;
                    else
                    begin
                        cur_col = 0;
                        for (c = tle_pkg::COLS - 1; c > 0; c--)
                        begin
                            if (scr_char[cur_row][c - 1] != tle_pkg::BLANK)
                            begin
                                cur_col = c;
                                break;
                            end
                        end
                    end
                end
                tle_pkg::KEY_ENTER:
                begin
                    cur_col     = 0;
                    cur_row     = (cur_row + 1) % tle_pkg::ROWS;
                    r.line_done = 1'b1;
                end
                default:
                begin
                    // Insert: shift right from the cursor, drop the last cell.
                    for (c = tle_pkg::COLS - 1; c > cur_col; c--)
                    begin
                        scr_char[cur_row][c]  = scr_char[cur_row][c - 1];
                        scr_color[cur_row][c] = scr_color[cur_row][c - 1];
                    end
                    scr_char[cur_row][cur_col]  = it.key_code;
                    scr_color[cur_row][cur_col] = ins_color;
                    if (cur_col + 1 < tle_pkg::COLS)
                        cur_col++;
                end
            endcase
        end
        r.cursor_column = 7'(cur_col);
        r.cursor_row    = 6'(cur_row);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------

    // Key press; the read fields carry random noise.
    function automatic tle_pkg::item_t key_word(logic [7:0] k);
        tle_pkg::item_t it;
        it.kind        = KIND_KEY;
        it.key_code    = k;
        it.read_row    = 6'($urandom_range(0, 63));
        it.read_column = 7'($urandom_range(0, 127));
        return it;
    endfunction

    // Cell read; the key field carries random noise.
    function automatic tle_pkg::item_t read_word(int row, int col);
        tle_pkg::item_t it;
        it.kind        = tle_pkg::KIND_READ;
        it.key_code    = 8'($urandom_range(0, 255));
        it.read_row    = 6'(row);
        it.read_column = 7'(col);
        return it;
    endfunction

    // Mostly printable text, some blanks, some arbitrary non-edit bytes.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0:       b = tle_pkg::BLANK;
            1:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == tle_pkg::KEY_BACKSPACE || b == tle_pkg::KEY_DELETE ||
                       b == tle_pkg::KEY_LEFT || b == tle_pkg::KEY_RIGHT ||
                       b == tle_pkg::KEY_HOME || b == tle_pkg::KEY_END ||
                       b == tle_pkg::KEY_ENTER);
            end
            default: b = 8'($urandom_range(8'h21, 8'h7E));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] edit_key();
        case ($urandom_range(0, 6))
            0:       return tle_pkg::KEY_BACKSPACE;
            1:       return tle_pkg::KEY_DELETE;
            2:       return tle_pkg::KEY_LEFT;
            3:       return tle_pkg::KEY_RIGHT;
            4:       return tle_pkg::KEY_HOME;
            5:       return tle_pkg::KEY_END;
            default: return tle_pkg::KEY_ENTER;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Send one word: idle a random gap, then hold it until accepted. The
    // model is advanced at the accepting edge. Valid stays high on return so
    // back-to-back words need no drop.
    task automatic send_word(tle_pkg::item_t it);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        awaited_words.push_back(edit_screen(it));
        words_sent++;
    endtask

    // Change the insert colour once every answer is in and the block is idle.
    task automatic set_text_color(logic [7:0] value);
        item_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        text_color_we <= 1'b1;
        text_color    <= value;
        @(posedge clk);
        text_color_we <= 1'b0;
        ins_color = value;
    endtask

    // Result side: stall a random number of cycles before each word, then
    // take the next word as soon as it shows up.
    initial
    begin : result_sink
        int n;
        forever
        begin
            n = $urandom_range(0, max_gap);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    // Compare each accepted word with the oldest awaited one, field by field.
    always @(posedge clk)
    begin : result_check
        tle_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected word: col %0d row %0d done %0b char %h color %h",
                             result.cursor_column, result.cursor_row, result.line_done,
                             result.cell_char, result.cell_color);
            end
            else
            begin
                want = awaited_words.pop_front();
                if (result.cursor_column !== want.cursor_column ||
                    result.cursor_row    !== want.cursor_row    ||
                    result.line_done     !== want.line_done     ||
                    result.cell_char     !== want.cell_char     ||
                    result.cell_color    !== want.cell_color)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: exp col %0d row %0d done %0b char %h color %h",
                                 want.cursor_column, want.cursor_row, want.line_done,
                                 want.cell_char, want.cell_color,
                                 " / got col %0d row %0d done %0b char %h color %h",
                                 result.cursor_column, result.cursor_row,
                                 result.line_done, result.cell_char, result.cell_color);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Cleared screen: corners read as blank with colour 0, out-of-range
    // columns read as zero.
    task automatic test_reset_contents();
        send_word(read_word(0, 0));
        send_word(read_word(tle_pkg::ROWS - 1, tle_pkg::COLS - 1));
        send_word(read_word(63, 127));
        send_word(read_word(0, tle_pkg::COLS));
    endtask

    // Extreme key bytes inserted with the reset colour.
    task automatic test_insert_reset_color();
        send_word(key_word(8'h00));
        send_word(key_word(8'hFF));
        send_word(read_word(0, 0));
        send_word(read_word(0, 1));
    endtask

    // End on a blank row gives 0; with a lone character in column 0 it gives 1.
    task automatic test_end_scan();
        send_word(key_word(tle_pkg::KEY_ENTER));
        send_word(key_word(tle_pkg::KEY_END));
        send_word(key_word("x"));
        send_word(key_word(tle_pkg::KEY_HOME));
        send_word(key_word(tle_pkg::KEY_END));
    endtask

    // Left, Backspace and Delete at column 0, Right and Backspace mid-row.
    task automatic test_cursor_moves();
        send_word(key_word(tle_pkg::KEY_HOME));
        send_word(key_word(tle_pkg::KEY_LEFT));
        send_word(key_word(tle_pkg::KEY_BACKSPACE));
        send_word(key_word(tle_pkg::KEY_DELETE));
        send_word(key_word(tle_pkg::KEY_END));
        send_word(key_word(tle_pkg::KEY_RIGHT));
        send_word(key_word(tle_pkg::KEY_RIGHT));
        send_word(key_word(tle_pkg::KEY_BACKSPACE));
        send_word(key_word(tle_pkg::KEY_LEFT));
    endtask

    // Insert colour at both extremes, read back.
    task automatic test_text_color();
        set_text_color(8'h00);
        send_word(key_word("q"));
        set_text_color(8'hFF);
        send_word(key_word("r"));
        send_word(read_word(cur_row, 0));
        send_word(read_word(cur_row, 1));
    endtask

    // Random editing sessions in phases; each phase ends with a new colour
    // and every fourth phase runs without gaps or stalls.
    task automatic test_random_editing();
        int          start;
        int          phase;
        int          phase_end;
        int          n;
        logic [31:0] raw;
        logic [7:0]  color;
        start = words_sent;
        phase = 0;
        while (words_sent - start < RANDOM_WORDS)
        begin
            max_gap   = (phase % 4 == 3) ? 0 : MAX_GAP;
            phase_end = words_sent + $urandom_range(120, 260);
            while (words_sent < phase_end && words_sent - start < RANDOM_WORDS)
            begin
                case ($urandom_range(0, 99)) inside
                    [0:69]:
                    begin
                        // Short typed line with edits, usually closed by Enter.
                        n = $urandom_range(1, 20);
                        repeat (n)
                        begin
                            case ($urandom_range(0, 9))
                                0, 1, 2: send_word(key_word(edit_key()));
                                3:       send_word(read_word(cur_row,
                                                   $urandom_range(0, tle_pkg::COLS - 1)));
                                default: send_word(key_word(text_byte()));
                            endcase
                        end
                        if ($urandom_range(0, 9) < 7)
                            send_word(key_word(tle_pkg::KEY_ENTER));
                    end
                    [70:74]:
                    begin
                        // Overfill a row: the cursor saturates, the last
                        // column drops, End meets a full last column.
                        send_word(key_word(tle_pkg::KEY_HOME));
                        n = $urandom_range(tle_pkg::COLS - 5, tle_pkg::COLS + 10);
                        repeat (n) send_word(key_word(text_byte()));
                        send_word(key_word(tle_pkg::KEY_RIGHT));
                        send_word(key_word(tle_pkg::KEY_END));
                        send_word(read_word(cur_row, tle_pkg::COLS - 1));
                        repeat ($urandom_range(1, 4)) send_word(key_word(edit_key()));
                        send_word(key_word(tle_pkg::KEY_END));
                    end
                    [75:89]:
                    begin
                        repeat ($urandom_range(1, 6))
                            send_word(read_word($urandom_range(0, 63),
                                                $urandom_range(0, 127)));
                    end
                    default:
                    begin
                        raw = $urandom;
                        send_word(tle_pkg::item_t'(raw[$bits(tle_pkg::item_t) - 1:0]));
                    end
                endcase
            end
            case ($urandom_range(0, 3))
                0:       color = 8'h00;
                1:       color = 8'hFF;
                default: color = 8'($urandom_range(0, 255));
            endcase
            set_text_color(color);
            phase++;
        end
        max_gap = MAX_GAP;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        for (int r = 0; r < tle_pkg::ROWS; r++)
        begin
            for (int c = 0; c < tle_pkg::COLS; c++)
            begin
                scr_char[r][c]  = tle_pkg::BLANK;
                scr_color[r][c] = 8'h00;
            end
        end
        cur_col   = 0;
        cur_row   = 0;
        ins_color = tle_pkg::COLOR_RESET;

        // Hold reset, release on an edge; the block then clears its screen
        // with item_stall high, which send_word simply waits out.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_contents();
        test_insert_reset_color();
        test_end_scan();
        test_cursor_moves();
        test_text_color();
        test_random_editing();

        // Drain: drop valid, wait for every answer, then let the block settle.
        item_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (tle_pkg::COLS + 8) @(posedge clk);

        if (fail_count == 0 && awaited_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: many times the slowest legal run, clearing pass included.
    initial
    begin : watchdog
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> text_line_editor.f
+incdir+rtl
rtl/tle_pkg.sv
rtl/tle_ram.sv
rtl/tle_engine.sv
rtl/text_line_editor.sv
tb/text_line_editor_tb.sv
